@@ design/cbe_pkg.sv @@
// Shared constants for the configurable CRC byte engine.
package cbe_pkg;

   localparam int CBE_MAX_WIDTH  = 64;
   localparam int BYTE_BITS      = 8;
   localparam int CRC_VALUE_BITS = 64;
   localparam int CRC_WIDTH_BITS = 7;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CRC_WIDTH      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_POLYNOMIAL     = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INITIAL_VALUE  = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FINAL_XOR      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFLECT_INPUT  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFLECT_OUTPUT = 3'd5;

   localparam logic [CRC_WIDTH_BITS-1:0] CRC_WIDTH_RESET     = 7'd32;
   localparam logic [CSR_DATA_BITS-1:0]  POLYNOMIAL_RESET    = 64'h0000_0000_04C1_1DB7;
   localparam logic [CSR_DATA_BITS-1:0]  INITIAL_VALUE_RESET = 64'h0000_0000_FFFF_FFFF;
   localparam logic [CSR_DATA_BITS-1:0]  FINAL_XOR_RESET     = 64'h0000_0000_FFFF_FFFF;
   localparam logic                      REFLECT_INPUT_RESET  = 1'b1;
   localparam logic                      REFLECT_OUTPUT_RESET = 1'b1;

endpackage

@@ design/configurable_crc_byte_engine.sv @@
// Top level of the configurable CRC byte engine.
// Takes one message byte per transaction and returns, per byte, the CRC of the message so far
// (width 8..MAX_WIDTH, polynomial, initial value, final XOR and input/output reflection set
// through the csr_ write port; the csr_ port is always ready). A byte with start_of_message
// restarts the CRC from the initial value. One byte per cycle while no stalled result
// blocks it; a byte passes the input register, then the result register; the combinational
// eight-step fold closes the accumulator loop. Register writes take effect for bytes accepted
// from the next cycle on; result bits at and above the active width read as zero.
module configurable_crc_byte_engine #(
   parameter int MAX_WIDTH = cbe_pkg::CBE_MAX_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cbe_pkg::BYTE_BITS-1:0]      req_data_byte,
   input  logic                               req_start_of_message,
   input  logic                               req_end_of_message,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [cbe_pkg::CRC_VALUE_BITS-1:0] rsp_crc_value,
   output logic                               rsp_message_done,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cbe_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [cbe_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import cbe_pkg::*;

   localparam int SHIFT_BITS = $clog2(MAX_WIDTH);
   localparam logic [CRC_WIDTH_BITS-1:0] MaxWidthCode = CRC_WIDTH_BITS'(MAX_WIDTH);
   localparam logic [CRC_WIDTH_BITS-1:0] MinWidthCode = CRC_WIDTH_BITS'(BYTE_BITS);

   logic [CRC_WIDTH_BITS-1:0] crc_width_ff;
   logic [MAX_WIDTH-1:0]      polynomial_ff;
   logic [MAX_WIDTH-1:0]      initial_value_ff;
   logic [MAX_WIDTH-1:0]      final_xor_ff;
   logic                      reflect_input_ff;
   logic                      reflect_output_ff;

   logic [CRC_WIDTH_BITS-1:0] width_eff;
   logic [SHIFT_BITS-1:0]     shift_in;
   logic [SHIFT_BITS-1:0]     shift_ff;
   logic [MAX_WIDTH-1:0]      mask_in;
   logic [MAX_WIDTH-1:0]      mask_ff;
   logic [MAX_WIDTH-1:0]      poly_aligned_ff;
   logic [MAX_WIDTH-1:0]      init_masked_ff;
   logic [MAX_WIDTH-1:0]      final_xor_masked_ff;

   logic                      s1_valid_ff;
   logic                      s1_valid_in;
   logic [BYTE_BITS-1:0]      s1_data_ff;
   logic                      s1_start_ff;
   logic                      s1_end_ff;

   logic                      rsp_valid_ff;
   logic [MAX_WIDTH-1:0]      rsp_crc_ff;
   logic                      rsp_done_ff;

   logic [MAX_WIDTH-1:0]      acc_ff;
   logic [MAX_WIDTH-1:0]      acc_in;
   logic [MAX_WIDTH-1:0]      base;
   logic [MAX_WIDTH-1:0]      folded;
   logic [MAX_WIDTH-1:0]      folded_rev;
   logic [MAX_WIDTH-1:0]      crc_in;

   logic                      out_free;
   logic                      req_accept;
   logic                      advance;
   logic                      csr_write;

   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid & csr_ready;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall  = s1_valid_ff & ~out_free;
   assign req_accept = req_valid & ~req_stall;
   assign advance    = s1_valid_ff & out_free;
   assign s1_valid_in = req_accept | (s1_valid_ff & ~out_free);

   always_comb begin
      width_eff = crc_width_ff;
      if (width_eff < MinWidthCode) begin
         width_eff = MinWidthCode;
      end
      if (width_eff > MaxWidthCode) begin
         width_eff = MaxWidthCode;
      end
      shift_in = SHIFT_BITS'(MaxWidthCode - width_eff);
      mask_in  = {MAX_WIDTH{1'b1}} >> shift_in;
   end

   always_comb begin
      base       = s1_start_ff ? init_masked_ff : (acc_ff & mask_ff);
      acc_in     = folded >> shift_ff;
      folded_rev = {<<{folded}};
      crc_in     = (reflect_output_ff ? folded_rev : acc_in) ^ final_xor_masked_ff;
   end

   cbe_fold #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_fold (
      .base         (base),
      .shift        (shift_ff),
      .poly_aligned (poly_aligned_ff),
      .data_byte    (s1_data_ff),
      .reflect_input(reflect_input_ff),
      .folded       (folded)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_width_ff      <= CRC_WIDTH_RESET;
         polynomial_ff     <= POLYNOMIAL_RESET[MAX_WIDTH-1:0];
         initial_value_ff  <= INITIAL_VALUE_RESET[MAX_WIDTH-1:0];
         final_xor_ff      <= FINAL_XOR_RESET[MAX_WIDTH-1:0];
         reflect_input_ff  <= REFLECT_INPUT_RESET;
         reflect_output_ff <= REFLECT_OUTPUT_RESET;
         acc_ff            <= INITIAL_VALUE_RESET[MAX_WIDTH-1:0];
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_CRC_WIDTH:      crc_width_ff      <= csr_data[CRC_WIDTH_BITS-1:0];
               CSR_POLYNOMIAL:     polynomial_ff     <= csr_data[MAX_WIDTH-1:0];
               CSR_INITIAL_VALUE:  initial_value_ff  <= csr_data[MAX_WIDTH-1:0];
               CSR_FINAL_XOR:      final_xor_ff      <= csr_data[MAX_WIDTH-1:0];
               CSR_REFLECT_INPUT:  reflect_input_ff  <= csr_data[0];
               CSR_REFLECT_OUTPUT: reflect_output_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         if (advance) begin
            acc_ff <= acc_in;
         end
         s1_valid_ff <= s1_valid_in;
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      shift_ff            <= shift_in;
      mask_ff             <= mask_in;
      poly_aligned_ff     <= (polynomial_ff & mask_in) << shift_in;
      init_masked_ff      <= initial_value_ff & mask_in;
      final_xor_masked_ff <= final_xor_ff & mask_in;
      if (req_accept) begin
         s1_data_ff  <= req_data_byte;
         s1_start_ff <= req_start_of_message;
         s1_end_ff   <= req_end_of_message;
      end
      if (advance) begin
         rsp_crc_ff  <= crc_in;
         rsp_done_ff <= s1_end_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_crc_value    = CRC_VALUE_BITS'(rsp_crc_ff);
   assign rsp_message_done = rsp_done_ff;

endmodule

@@ design/cbe_fold.sv @@
// Eight-bit CRC fold of one message byte into a left-aligned accumulator.
module cbe_fold #(
   parameter int MAX_WIDTH = cbe_pkg::CBE_MAX_WIDTH
) (
   input  logic [MAX_WIDTH-1:0]         base,
   input  logic [$clog2(MAX_WIDTH)-1:0] shift,
   input  logic [MAX_WIDTH-1:0]         poly_aligned,
   input  logic [cbe_pkg::BYTE_BITS-1:0] data_byte,
   input  logic                         reflect_input,
   output logic [MAX_WIDTH-1:0]         folded
);
   import cbe_pkg::*;

   logic [BYTE_BITS-1:0] data_rev;
   logic [BYTE_BITS-1:0] data_bits;

   assign data_rev = {<<{data_byte}};

   always_comb begin
      data_bits = reflect_input ? data_rev : data_byte;
      folded    = (base << shift) ^ (MAX_WIDTH'(data_bits) << (MAX_WIDTH - BYTE_BITS));
      for (int i = 0; i < BYTE_BITS; i++) begin
         if (folded[MAX_WIDTH-1]) begin
            folded = (folded << 1) ^ poly_aligned;
         end else begin
            folded = folded << 1;
         end
      end
   end

endmodule

@@ design/cbe_checker.sv @@
// Port-level assertions for the configurable CRC byte engine, bound to the top level.
module cbe_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic [cbe_pkg::CRC_VALUE_BITS-1:0] rsp_crc_value,
   input logic                               rsp_message_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crc_value)
         && $stable(rsp_message_done))
      else $error("stalled result transaction changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted transaction did not reach the result register");

endmodule

bind configurable_crc_byte_engine cbe_checker u_cbe_checker (.*);
